### rtl/priority_claim_owner_table_assert.svh
// assertion macros used by the claim table top level
`ifndef PRIORITY_CLAIM_OWNER_TABLE_ASSERT_SVH
`define PRIORITY_CLAIM_OWNER_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PCOT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PCOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pcot_pkg.sv
package pcot_pkg;

  // field widths of the transfer payloads
  localparam int OP_FIELD_BITS      = 2;
  localparam int TAG_FIELD_BITS     = 16;
  localparam int PRIO_FIELD_BITS    = 16;
  localparam int PAYLOAD_FIELD_BITS = 64;
  localparam int STATUS_FIELD_BITS  = 3;

  // stored claim widths
  localparam int PRIO_BITS = 15;
  localparam int SEQ_BITS  = 32;

  typedef enum logic [OP_FIELD_BITS-1:0] {
    OP_SET       = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_GET       = 2'd2,
    OP_CLEAR_ALL = 2'd3
  } pcot_op_t;

  typedef enum logic [STATUS_FIELD_BITS-1:0] {
    ST_OK         = 3'd0,
    ST_EMPTY_TAG  = 3'd1,
    ST_NEG_PRIO   = 3'd2,
    ST_NOT_FINITE = 3'd3,
    ST_FULL       = 3'd4,
    ST_NO_OWNER   = 3'd5
  } pcot_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } pcot_state_t;

  // flags carried by the scan token from cell to cell
  typedef struct packed {
    logic active;
    logic hit;
    logic free;
    logic best;
  } pcot_scan_t;

  // broadcast control from the sequencer to a row
  typedef struct packed {
    pcot_op_t op;
    logic     clear_all;
    logic     wr_en;
  } pcot_ctrl_t;

endpackage

### rtl/pcot_req_if.sv
interface pcot_req_if import pcot_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic [OP_FIELD_BITS-1:0]      op;
  logic                          side;
  logic [TAG_FIELD_BITS-1:0]     tag_id;
  logic signed [PRIO_FIELD_BITS-1:0] priority_req;
  logic [PAYLOAD_FIELD_BITS-1:0] payload;
  logic                          payload_finite;

  modport source (
    output valid, op, side, tag_id, priority_req, payload, payload_finite,
    input  ready
  );

  modport sink (
    input  valid, op, side, tag_id, priority_req, payload, payload_finite,
    output ready
  );
endinterface

### rtl/pcot_rsp_if.sv
interface pcot_rsp_if import pcot_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic [STATUS_FIELD_BITS-1:0]  status;
  logic [PAYLOAD_FIELD_BITS-1:0] owner_payload;

  modport source (
    output valid, status, owner_payload,
    input  ready
  );

  modport sink (
    input  valid, status, owner_payload,
    output ready
  );
endinterface

### rtl/pcot_cell.sv
module pcot_cell import pcot_pkg::*; #(
  parameter int TAG_BITS     = 16,
  parameter int PAYLOAD_BITS = 64,
  parameter int IDX_BITS     = 4,
  parameter int CELL_IDX     = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pcot_ctrl_t              ctrl,
  input  logic [IDX_BITS-1:0]     wr_idx,
  input  logic [TAG_BITS-1:0]     cmd_tag,
  input  logic [PRIO_BITS-1:0]    cmd_prio,
  input  logic [SEQ_BITS-1:0]     cmd_seq,
  input  logic [PAYLOAD_BITS-1:0] cmd_payload,
  input  pcot_scan_t              scan_in,
  input  logic [IDX_BITS-1:0]     hit_idx_in,
  input  logic [IDX_BITS-1:0]     free_idx_in,
  input  logic [PRIO_BITS-1:0]    best_prio_in,
  input  logic [SEQ_BITS-1:0]     best_seq_in,
  input  logic [PAYLOAD_BITS-1:0] best_payload_in,
  output pcot_scan_t              scan_out,
  output logic [IDX_BITS-1:0]     hit_idx_out,
  output logic [IDX_BITS-1:0]     free_idx_out,
  output logic [PRIO_BITS-1:0]    best_prio_out,
  output logic [SEQ_BITS-1:0]     best_seq_out,
  output logic [PAYLOAD_BITS-1:0] best_payload_out
);

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

  logic                    valid;
  logic [TAG_BITS-1:0]     tag;
  logic [PRIO_BITS-1:0]    prio;
  logic [SEQ_BITS-1:0]     seq;
  logic [PAYLOAD_BITS-1:0] payload;

  logic       match;
  logic       better;
  logic       wr_here;
  pcot_scan_t scan_next;

  assign match   = valid && (tag == cmd_tag);
  assign wr_here = ctrl.wr_en && (wr_idx == MY_IDX);
  assign better  = valid && (!scan_in.best || (prio > best_prio_in) ||
                   ((prio == best_prio_in) && (seq > best_seq_in)));

  always_comb begin
    scan_next.active = scan_in.active;
    scan_next.hit    = scan_in.hit || match;
    scan_next.free   = scan_in.free || !valid;
    scan_next.best   = scan_in.best || valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      scan_out <= '0;
    end else begin
      scan_out <= scan_next;
      if (ctrl.clear_all) begin
        valid <= 1'b0;
      end else if (wr_here) begin
        valid <= 1'b1;
      end else if (scan_in.active && (ctrl.op == OP_CLEAR) && match) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      tag     <= cmd_tag;
      prio    <= cmd_prio;
      seq     <= cmd_seq;
      payload <= cmd_payload;
    end
    // first match and first free slot win, later cells only pass them on
    hit_idx_out  <= scan_in.hit  ? hit_idx_in  : MY_IDX;
    free_idx_out <= scan_in.free ? free_idx_in : MY_IDX;
    if (better) begin
      best_prio_out    <= prio;
      best_seq_out     <= seq;
      best_payload_out <= payload;
    end else begin
      best_prio_out    <= best_prio_in;
      best_seq_out     <= best_seq_in;
      best_payload_out <= best_payload_in;
    end
  end

endmodule

### rtl/pcot_row.sv
module pcot_row import pcot_pkg::*; #(
  parameter int ENTRIES      = 16,
  parameter int TAG_BITS     = 16,
  parameter int PAYLOAD_BITS = 64,
  parameter int IDX_BITS     = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  pcot_ctrl_t              ctrl,
  input  logic [IDX_BITS-1:0]     wr_idx,
  input  logic [TAG_BITS-1:0]     cmd_tag,
  input  logic [PRIO_BITS-1:0]    cmd_prio,
  input  logic [SEQ_BITS-1:0]     cmd_seq,
  input  logic [PAYLOAD_BITS-1:0] cmd_payload,
  output pcot_scan_t              scan_out,
  output logic [IDX_BITS-1:0]     hit_idx,
  output logic [IDX_BITS-1:0]     free_idx,
  output logic [PAYLOAD_BITS-1:0] best_payload
);

  pcot_scan_t              scan_c    [ENTRIES+1];
  logic [IDX_BITS-1:0]     hit_c     [ENTRIES+1];
  logic [IDX_BITS-1:0]     free_c    [ENTRIES+1];
  logic [PRIO_BITS-1:0]    prio_c    [ENTRIES+1];
  logic [SEQ_BITS-1:0]     seq_c     [ENTRIES+1];
  logic [PAYLOAD_BITS-1:0] payload_c [ENTRIES+1];

  // token enters the head of the row empty-handed
  always_comb begin
    scan_c[0]        = '0;
    scan_c[0].active = start;
    hit_c[0]         = '0;
    free_c[0]        = '0;
    prio_c[0]        = '0;
    seq_c[0]         = '0;
    payload_c[0]     = '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pcot_cell #(
      .TAG_BITS     (TAG_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .IDX_BITS     (IDX_BITS),
      .CELL_IDX     (i)
    ) u_cell (
      .clk              (clk),
      .rst              (rst),
      .ctrl             (ctrl),
      .wr_idx           (wr_idx),
      .cmd_tag          (cmd_tag),
      .cmd_prio         (cmd_prio),
      .cmd_seq          (cmd_seq),
      .cmd_payload      (cmd_payload),
      .scan_in          (scan_c[i]),
      .hit_idx_in       (hit_c[i]),
      .free_idx_in      (free_c[i]),
      .best_prio_in     (prio_c[i]),
      .best_seq_in      (seq_c[i]),
      .best_payload_in  (payload_c[i]),
      .scan_out         (scan_c[i+1]),
      .hit_idx_out      (hit_c[i+1]),
      .free_idx_out     (free_c[i+1]),
      .best_prio_out    (prio_c[i+1]),
      .best_seq_out     (seq_c[i+1]),
      .best_payload_out (payload_c[i+1])
    );
  end

  assign scan_out     = scan_c[ENTRIES];
  assign hit_idx      = hit_c[ENTRIES];
  assign free_idx     = free_c[ENTRIES];
  assign best_payload = payload_c[ENTRIES];

endmodule

### rtl/priority_claim_owner_table.sv
// set, clear and get send a token along the cell row of the chosen side, then enter the write
//   state; set with a bad field, clear with empty tag and clear-all go straight to write
// the block takes a new item only once the last one has committed its result; the token walks
//   the cell row one cell per cycle, and the write state waits for room in the output register
// reset: synchronous, clears all claim valid bits, the sequence counter and control at once;
//   no clearing pass is needed
`include "priority_claim_owner_table_assert.svh"

module priority_claim_owner_table import pcot_pkg::*; #(
  parameter int ENTRIES_PER_SIDE = 16,
  parameter int TAG_BITS         = 16,
  parameter int PAYLOAD_BITS     = 64
) (
  input logic       clk,
  input logic       rst,
  pcot_req_if.sink  req,
  pcot_rsp_if.source rsp
);

  localparam int IDX_BITS = (ENTRIES_PER_SIDE > 1) ? $clog2(ENTRIES_PER_SIDE) : 1;
  // tag bits that survive masking of the 16 bit field
  localparam int TAG_KEEP = (TAG_BITS < TAG_FIELD_BITS) ? TAG_BITS : TAG_FIELD_BITS;
  localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;

  // sequencer state and the held command
  pcot_state_t             state;
  pcot_state_t             state_next;
  pcot_op_t                op_r;
  logic                    side_r;
  logic [TAG_BITS-1:0]     tag_r;
  logic [PRIO_BITS-1:0]    prio_r;
  logic [PAYLOAD_BITS-1:0] payload_r;
  pcot_status_t            status_r;
  logic [PAYLOAD_BITS-1:0] result_r;
  logic [IDX_BITS-1:0]     wr_idx_r;
  logic                    wr_pending;
  logic                    start;
  logic [SEQ_BITS-1:0]     seq_counter;
  logic [SEQ_BITS-1:0]     seq_stamp;

  // output register
  logic                          out_valid;
  pcot_status_t                  out_status;
  logic [PAYLOAD_FIELD_BITS-1:0] out_payload;

  logic                    accept;
  logic                    commit;
  logic                    done;
  logic [TAG_BITS-1:0]     tag_in;
  pcot_ctrl_t              ctrl0;
  pcot_ctrl_t              ctrl1;
  pcot_scan_t              scan0;
  pcot_scan_t              scan1;
  pcot_scan_t              scan_sel;
  logic [IDX_BITS-1:0]     hit_idx0, hit_idx1, hit_idx_sel;
  logic [IDX_BITS-1:0]     free_idx0, free_idx1, free_idx_sel;
  logic [PAYLOAD_BITS-1:0] best0, best1, best_sel;

  assign tag_in = TAG_BITS'(req.tag_id[TAG_KEEP-1:0]);

  // the block takes a new item only between items; a pending result does not block it
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // write cycle finishes once the output register has room
  assign commit = (state == S_WRITE) && (!out_valid || rsp.ready);

  // counter saturates at all ones
  assign seq_stamp = (seq_counter == SEQ_MAX) ? seq_counter : seq_counter + 1'b1;

  // token leaving the tail of the selected row
  assign scan_sel     = side_r ? scan1 : scan0;
  assign hit_idx_sel  = side_r ? hit_idx1 : hit_idx0;
  assign free_idx_sel = side_r ? free_idx1 : free_idx0;
  assign best_sel     = side_r ? best1 : best0;
  assign done         = (state == S_SCAN) && scan_sel.active;

  always_comb begin
    ctrl0.op        = op_r;
    ctrl0.clear_all = commit && (op_r == OP_CLEAR_ALL);
    ctrl0.wr_en     = commit && wr_pending && !side_r;
    ctrl1.op        = op_r;
    ctrl1.clear_all = commit && (op_r == OP_CLEAR_ALL);
    ctrl1.wr_en     = commit && wr_pending && side_r;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (pcot_op_t'(req.op))
            OP_SET: begin
              if ((tag_in == '0) || req.priority_req[PRIO_FIELD_BITS-1] ||
                  !req.payload_finite) begin
                state_next = S_WRITE;
              end else begin
                state_next = S_SCAN;
              end
            end
            OP_CLEAR: state_next = (tag_in == '0) ? S_WRITE : S_SCAN;
            OP_GET:   state_next = S_SCAN;
            default:  state_next = S_WRITE;
          endcase
        end
      end
      S_SCAN: begin
        if (done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start       <= 1'b0;
      wr_pending  <= 1'b0;
      seq_counter <= '0;
      out_valid   <= 1'b0;
    end else begin
      start <= accept && (state_next == S_SCAN);
      if (accept) begin
        wr_pending <= 1'b0;
      end else if (done) begin
        // set writes to its matching claim, else to the lowest free slot
        wr_pending <= (op_r == OP_SET) && (scan_sel.hit || scan_sel.free);
      end
      if (commit && (op_r == OP_CLEAR_ALL)) begin
        seq_counter <= '0;
      end else if (commit && wr_pending) begin
        seq_counter <= seq_stamp;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // command and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= pcot_op_t'(req.op);
      side_r    <= req.side;
      tag_r     <= tag_in;
      prio_r    <= req.priority_req[PRIO_BITS-1:0];
      payload_r <= req.payload[PAYLOAD_BITS-1:0];
      result_r  <= '0;
      status_r  <= ST_OK;
      unique case (pcot_op_t'(req.op))
        OP_SET: begin
          if (tag_in == '0) begin
            status_r <= ST_EMPTY_TAG;
          end else if (req.priority_req[PRIO_FIELD_BITS-1]) begin
            status_r <= ST_NEG_PRIO;
          end else if (!req.payload_finite) begin
            status_r <= ST_NOT_FINITE;
          end
        end
        OP_CLEAR: begin
          if (tag_in == '0) begin
            status_r <= ST_EMPTY_TAG;
          end
        end
        default: ;
      endcase
    end else if (done) begin
      unique case (op_r)
        OP_SET: begin
          if (scan_sel.hit) begin
            wr_idx_r <= hit_idx_sel;
          end else if (scan_sel.free) begin
            wr_idx_r <= free_idx_sel;
          end else begin
            status_r <= ST_FULL;
          end
        end
        OP_GET: begin
          if (scan_sel.best) begin
            result_r <= best_sel;
          end else begin
            status_r <= ST_NO_OWNER;
          end
        end
        default: ;
      endcase
    end
    if (commit) begin
      out_status  <= status_r;
      out_payload <= PAYLOAD_FIELD_BITS'(result_r);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.owner_payload = out_payload;

  // right hand row
  pcot_row #(
    .ENTRIES      (ENTRIES_PER_SIDE),
    .TAG_BITS     (TAG_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .IDX_BITS     (IDX_BITS)
  ) u_row0 (
    .clk          (clk),
    .rst          (rst),
    .start        (start && !side_r),
    .ctrl         (ctrl0),
    .wr_idx       (wr_idx_r),
    .cmd_tag      (tag_r),
    .cmd_prio     (prio_r),
    .cmd_seq      (seq_stamp),
    .cmd_payload  (payload_r),
    .scan_out     (scan0),
    .hit_idx      (hit_idx0),
    .free_idx     (free_idx0),
    .best_payload (best0)
  );

  // left hand row
  pcot_row #(
    .ENTRIES      (ENTRIES_PER_SIDE),
    .TAG_BITS     (TAG_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .IDX_BITS     (IDX_BITS)
  ) u_row1 (
    .clk          (clk),
    .rst          (rst),
    .start        (start && side_r),
    .ctrl         (ctrl1),
    .wr_idx       (wr_idx_r),
    .cmd_tag      (tag_r),
    .cmd_prio     (prio_r),
    .cmd_seq      (seq_stamp),
    .cmd_payload  (payload_r),
    .scan_out     (scan1),
    .hit_idx      (hit_idx1),
    .free_idx     (free_idx1),
    .best_payload (best1)
  );

  // only one row ever carries a token
  `PCOT_ASSERT_NOW(a_one_token, clk, rst, 1'b1, $onehot0({scan0.active, scan1.active}), "token in both rows")
  // token reaches the tail only while the sequencer scans
  `PCOT_ASSERT_NOW(a_tail_in_scan, clk, rst, scan_sel.active, state == S_SCAN, "token outside scan")
  // counter moves only on a committed write or clear-all
  `PCOT_ASSERT_NEXT(a_seq_stable, clk, rst, !commit, $stable(seq_counter), "counter moved")
  // a result appears only out of the write cycle
  `PCOT_ASSERT_NOW(a_result_src, clk, rst, $rose(out_valid), $past(state == S_WRITE), "stray result")

endmodule

### sim/priority_claim_owner_table_tb.sv
module priority_claim_owner_table_tb import pcot_pkg::*;;

  localparam int ENTRIES      = 16;
  localparam int SLOTS        = 2 * ENTRIES;
  localparam int TAG_POOL     = 20;          // more tags than slots per side, so sides can fill up
  localparam int HOLD_CYCLES  = 600;         // long receiver hold-off in the last phase
  localparam int SETTLE       = 2 * (ENTRIES + 3);
  localparam int RANDOM_ITEMS = 1520;

  // one request as it goes over the request channel
  typedef struct {
    pcot_op_t                          op;
    logic                              side;
    logic [TAG_FIELD_BITS-1:0]         tag;
    logic signed [PRIO_FIELD_BITS-1:0] prio;
    logic [PAYLOAD_FIELD_BITS-1:0]     payload;
    logic                              finite;
  } claim_req_t;

  // one reply as it comes back on the response channel
  typedef struct {
    pcot_status_t                  status;
    logic [PAYLOAD_FIELD_BITS-1:0] owner_payload;
  } claim_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  pcot_req_if req_bus ();
  pcot_rsp_if rsp_bus ();

  priority_claim_owner_table #(
    .ENTRIES_PER_SIDE (ENTRIES),
    .TAG_BITS         (TAG_FIELD_BITS),
    .PAYLOAD_BITS     (PAYLOAD_FIELD_BITS)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // shadow copy of both claim tables, right hand in slots 0..15, left hand above
  bit                        slot_valid [SLOTS];
  bit [TAG_FIELD_BITS-1:0]   slot_tag   [SLOTS];
  bit [PRIO_BITS-1:0]        slot_prio  [SLOTS];
  bit [SEQ_BITS-1:0]         slot_seq   [SLOTS];
  bit [PAYLOAD_FIELD_BITS-1:0] slot_payload [SLOTS];
  bit [SEQ_BITS-1:0]         seq_count;

  claim_req_t   claim_reqs_pending [$];
  claim_reply_t due_replies        [$];
  claim_req_t   req_in_flight;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic rsp_hold = 1'b0;
  bit hold_go = 1'b0;

  int reqs_queued  = 0;
  int replies_seen = 0;
  int err_count    = 0;
  int status_tally [8];

  function automatic void report_error(string msg);
    err_count++;
    if (err_count <= 10) $display("[%0t] error: %s", $realtime, msg);
  endfunction

  // advance the shadow tables by one accepted request and return the reply it causes
  function automatic claim_reply_t claim_table_step(claim_req_t it);
    claim_reply_t r;
    int base;
    int hit;
    int free_slot;
    int best;
    int k;
    r.status        = ST_OK;
    r.owner_payload = '0;
    base = it.side ? ENTRIES : 0;
    case (it.op)
      OP_SET: begin
        // checks in fixed order: empty tag, negative priority, non-finite payload
        if (it.tag == '0) r.status = ST_EMPTY_TAG;
        else if (it.prio[PRIO_FIELD_BITS-1]) r.status = ST_NEG_PRIO;
        else if (!it.finite) r.status = ST_NOT_FINITE;
        else begin
          hit       = -1;
          free_slot = -1;
          for (k = base; k < base + ENTRIES; k++) begin
            if (slot_valid[k]) begin
              if (hit < 0 && slot_tag[k] == it.tag) hit = k;
            end else if (free_slot < 0) begin
              free_slot = k;
            end
          end
          if (hit < 0 && free_slot < 0) begin
            r.status = ST_FULL;
          end else begin
            if (hit < 0) begin
              hit = free_slot;
              slot_valid[hit] = 1'b1;
              slot_tag[hit]   = it.tag;
            end
            // shared counter saturates at all ones
            if (seq_count != '1) seq_count++;
            slot_prio[hit]    = it.prio[PRIO_BITS-1:0];
            slot_payload[hit] = it.payload;
            slot_seq[hit]     = seq_count;
          end
        end
      end
      OP_CLEAR: begin
        if (it.tag == '0) r.status = ST_EMPTY_TAG;
        else begin
          for (k = base; k < base + ENTRIES; k++)
            if (slot_valid[k] && slot_tag[k] == it.tag) slot_valid[k] = 1'b0;
        end
      end
      OP_GET: begin
        // highest priority wins, then latest sequence, then lowest slot
        best = -1;
        for (k = base; k < base + ENTRIES; k++) begin
          if (slot_valid[k]) begin
            if (best < 0 || slot_prio[k] > slot_prio[best] ||
                (slot_prio[k] == slot_prio[best] && slot_seq[k] > slot_seq[best]))
              best = k;
          end
        end
        if (best < 0) r.status = ST_NO_OWNER;
        else r.owner_payload = slot_payload[best];
      end
      default: begin
        for (k = 0; k < SLOTS; k++) slot_valid[k] = 1'b0;
        seq_count = '0;
      end
    endcase
    return r;
  endfunction

  function automatic claim_req_t make_req(pcot_op_t op, logic side,
                                          logic [TAG_FIELD_BITS-1:0] tag,
                                          logic signed [PRIO_FIELD_BITS-1:0] prio,
                                          logic [PAYLOAD_FIELD_BITS-1:0] payload,
                                          logic finite);
    claim_req_t it;
    it.op      = op;
    it.side    = side;
    it.tag     = tag;
    it.prio    = prio;
    it.payload = payload;
    it.finite  = finite;
    return it;
  endfunction

  // mostly well-formed claims on a small tag pool, with some noise and bad fields
  function automatic claim_req_t random_req();
    claim_req_t it;
    int pick;
    it.payload = {$urandom, $urandom};
    it.side    = 1'($urandom_range(1));
    it.finite  = ($urandom_range(99) < 95);
    pick = $urandom_range(999);
    if (pick < 500) it.op = OP_SET;
    else if (pick < 630) it.op = OP_CLEAR;
    else if (pick < 985) it.op = OP_GET;
    else it.op = OP_CLEAR_ALL;
    pick = $urandom_range(99);
    if (pick < 78) it.tag = 16'($urandom_range(TAG_POOL, 1));
    else if (pick < 93) it.tag = 16'($urandom);
    else if (pick < 97) it.tag = '0;
    else it.tag = '1;
    pick = $urandom_range(99);
    // small priorities give plenty of ties settled by sequence
    if (pick < 70) it.prio = 16'($urandom_range(3));
    else if (pick < 85) it.prio = 16'($urandom_range(16'h7fff));
    else if (pick < 95) it.prio = 16'($urandom);
    else it.prio = 16'sh7fff;
    return it;
  endfunction

  // request driver: a transfer completes where valid and ready meet at an edge
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready)
        due_replies.insert(due_replies.size(), claim_table_step(req_in_flight));
      if (!req_bus.valid || req_bus.ready) begin
        if (claim_reqs_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_in_flight = claim_reqs_pending.pop_front();
          req_bus.valid          <= 1'b1;
          req_bus.op             <= req_in_flight.op;
          req_bus.side           <= req_in_flight.side;
          req_bus.tag_id         <= req_in_flight.tag;
          req_bus.priority_req   <= req_in_flight.prio;
          req_bus.payload        <= req_in_flight.payload;
          req_bus.payload_finite <= req_in_flight.finite;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // reply monitor and receiver backpressure
  always @(posedge clk) begin
    claim_reply_t want;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        replies_seen++;
        if (due_replies.size() == 0) begin
          report_error($sformatf("reply with nothing pending: status %0d payload %h",
                                 rsp_bus.status, rsp_bus.owner_payload));
        end else begin
          want = due_replies.pop_front();
          status_tally[want.status]++;
          if (rsp_bus.status !== want.status || rsp_bus.owner_payload !== want.owner_payload)
            report_error($sformatf(
              "reply %0d: expected status %0d payload %h, got status %0d payload %h",
              replies_seen, want.status, want.owner_payload,
              rsp_bus.status, rsp_bus.owner_payload));
        end
      end
      rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (hold_go);
    repeat (40) @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  initial begin
    #3200000;
    $display("timeout: %0d of %0d replies seen", replies_seen, reqs_queued);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic queue_req(claim_req_t it);
    claim_reqs_pending.insert(claim_reqs_pending.size(), it);
    reqs_queued++;
  endtask

  task automatic wait_drained();
    wait (replies_seen == reqs_queued);
    @(posedge clk);
  endtask

  initial begin
    int i;
    int phase;
    req_bus.valid          = 1'b0;
    req_bus.op             = OP_GET;
    req_bus.side           = 1'b0;
    req_bus.tag_id         = '0;
    req_bus.priority_req   = '0;
    req_bus.payload        = '0;
    req_bus.payload_finite = 1'b0;
    rsp_bus.ready          = 1'b0;
    seq_count              = '0;
    for (i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
    for (i = 0; i < 8; i++) status_tally[i] = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 16;
    recv_idle_pct = 87;

    // directed: empty table, each rejected set, clear corner cases, extremes
    queue_req(make_req(OP_GET,   1'b0, 16'h0001, 16'sh0001, 64'h1, 1'b1));
    queue_req(make_req(OP_SET,   1'b0, 16'h0000, 16'sh0001, 64'h1, 1'b1));
    queue_req(make_req(OP_SET,   1'b0, 16'h0002, -16'sh8000, 64'h2, 1'b1));
    queue_req(make_req(OP_SET,   1'b0, 16'h0003, 16'sh0001, 64'h3, 1'b0));
    queue_req(make_req(OP_CLEAR, 1'b0, 16'h0000, 16'sh0000, 64'h0, 1'b1));
    queue_req(make_req(OP_CLEAR, 1'b0, 16'h0044, 16'sh0000, 64'h0, 1'b1));
    queue_req(make_req(OP_SET,   1'b1, 16'hffff, 16'sh7fff, '1, 1'b1));
    queue_req(make_req(OP_SET,   1'b1, 16'h0001, 16'sh0000, '0, 1'b1));
    queue_req(make_req(OP_GET,   1'b1, 16'h0000, -16'sh0001, '1, 1'b0));
    // clear-all with junk in every other field
    queue_req(make_req(OP_CLEAR_ALL, 1'b1, 16'h0000, -16'sh0001, '1, 1'b0));
    queue_req(make_req(OP_GET,   1'b1, 16'hffff, 16'sh7fff, 64'h0, 1'b1));
    // fill the right hand side, then one new tag too many, then update in place
    for (i = 0; i < ENTRIES; i++)
      queue_req(make_req(OP_SET, 1'b0, 16'(16'h0100 + i), 16'(i % 4),
                         {$urandom, $urandom}, 1'b1));
    queue_req(make_req(OP_SET,   1'b0, 16'h0200, 16'sh0001, 64'h5, 1'b1));
    queue_req(make_req(OP_SET,   1'b0, 16'h0103, 16'sh0003, 64'h6, 1'b1));
    queue_req(make_req(OP_GET,   1'b0, 16'h0000, 16'sh0000, 64'h0, 1'b1));
    // sender waits here until every reply is back
    wait_drained();

    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 87;
        recv_idle_pct = 16;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b1;
      end
      for (i = 0; i < RANDOM_ITEMS / 3; i++) queue_req(random_req());
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk);
    if (due_replies.size() != 0)
      report_error($sformatf("%0d replies never arrived", due_replies.size()));

    $display("covered %0d transfers: ok %0d, empty tag %0d, negative priority %0d,",
             replies_seen, status_tally[ST_OK], status_tally[ST_EMPTY_TAG],
             status_tally[ST_NEG_PRIO]);
    $display("  not finite %0d, table full %0d, no owner %0d; %0d errors",
             status_tally[ST_NOT_FINITE], status_tally[ST_FULL],
             status_tally[ST_NO_OWNER], err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/pcot_pkg.sv
rtl/pcot_req_if.sv
rtl/pcot_rsp_if.sv
rtl/pcot_cell.sv
rtl/pcot_row.sv
rtl/priority_claim_owner_table.sv
sim/priority_claim_owner_table_tb.sv
